[hw/rtl/pctd_pkg.sv]
// Shared types and constants of the trial-division prime counter.
// Used by the remainder unit, the core and the port checker; depends on nothing.
`default_nettype none

package pctd_pkg;

	localparam int COUNT_W = 21;
	localparam int CHUNK_W = 21;

	localparam logic [63:0]        LIMIT_RESET   = 64'd1000000;
	localparam logic [CHUNK_W-1:0] CHUNK_RESET   = 21'd500000;
	localparam int                 FIRST_DIVISOR = 3;
	localparam logic [COUNT_W-1:0] COUNT_MAX     = 21'h100000;

	// configuration register indexes
	localparam logic REG_UPPER_LIMIT = 1'b0;
	localparam logic REG_CHUNK_SIZE  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CAND,
		ST_TRIAL,
		ST_DIV,
		ST_FINISH
	} pctd_state_t;

	typedef struct packed {
		logic done;
		logic rem_zero;
	} pctd_div_status_t;

endpackage

`default_nettype wire

[hw/rtl/pctd_rem_unit.sv]
// Iterative remainder unit: restoring division, one dividend bit per cycle.
// Depends on pctd_pkg for the status struct.
`default_nettype none

module pctd_rem_unit #(
	parameter int VALUE_BITS = 31
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [VALUE_BITS-1:0]         dividend,
	input  wire logic [VALUE_BITS-1:0]         divisor,
	output pctd_pkg::pctd_div_status_t         status
);
	import pctd_pkg::*;

	localparam int CNT_W = $clog2(VALUE_BITS + 1);

	logic [VALUE_BITS-1:0] rem_q;
	logic [VALUE_BITS-1:0] shift_q;
	logic [VALUE_BITS-1:0] dsr_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [VALUE_BITS:0]   trial;
	logic [VALUE_BITS:0]   diff;
	logic                  fits;

	assign trial = {rem_q, shift_q[VALUE_BITS-1]};
	assign fits  = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(VALUE_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= '0;
			shift_q <= dividend;
			dsr_q   <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so the top bit drops
			rem_q   <= fits ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
			shift_q <= {shift_q[VALUE_BITS-2:0], 1'b0};
		end
	end

	assign status.done     = done_q;
	assign status.rem_zero = (rem_q == '0);

endmodule

`default_nettype wire

[hw/rtl/prime_count_trial_division_core.sv]
// Top level of the trial-division prime counter: config registers, sequencer, output register.
// Depends on pctd_pkg and pctd_rem_unit.
//
//   channel   signals                          direction  moves
//   in        in_valid/in_ready, range_start   sink       one range word
//   out       out_valid/out_ready, prime_count source     one count word
//   cfg       cfg_we, cfg_index, cfg_data      sink       register write, no wait
//
// Each odd divisor tried costs one pass through the shared bit-serial remainder unit,
// which sets the pace.
// Reset (arst_n low) clears the sequencer and loads upper_limit and chunk_size defaults.
// in_ready is high only in idle; a finished count waits in the output register while
// the next range word is taken, and the sequencer holds at its end until that register frees.
`default_nettype none

module prime_count_trial_division_core #(
	parameter int VALUE_BITS = 31
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     in_valid,
	output logic                                          in_ready,
	input  wire logic [VALUE_BITS-1:0]                    range_start,
	output logic                                          out_valid,
	input  wire logic                                     out_ready,
	output logic [pctd_pkg::COUNT_W-1:0]                  prime_count,
	input  wire logic                                     cfg_we,
	input  wire logic                                     cfg_index,
	input  wire logic [((VALUE_BITS > pctd_pkg::CHUNK_W) ?
		VALUE_BITS : pctd_pkg::CHUNK_W)-1:0]              cfg_data
);
	import pctd_pkg::*;

	localparam int CAND_W = VALUE_BITS + 1;
	localparam int SQ_W   = VALUE_BITS + 2;
	localparam int SUM_W  = ((VALUE_BITS > CHUNK_W) ? VALUE_BITS : CHUNK_W) + 1;

	pctd_state_t state_q, state_d;

	logic [VALUE_BITS-1:0] limit_q;
	logic [CHUNK_W-1:0]    chunk_q;
	logic [VALUE_BITS-1:0] end_q;
	logic [CAND_W-1:0]     cand_q;
	logic [VALUE_BITS-1:0] div_q;
	logic [SQ_W-1:0]       sq_q;
	logic [COUNT_W-1:0]    count_q;
	logic                  out_valid_q;
	logic [COUNT_W-1:0]    out_count_q;

	logic [SUM_W-1:0]      range_sum;
	logic [SUM_W-1:0]      limit_ext;
	logic [SUM_W-1:0]      range_end;
	logic                  cand_live;
	logic                  sq_in_range;
	logic                  out_free;
	pctd_div_status_t      div_status;

	// sequencer strobes
	logic accept;
	logic div_start;
	logic cand_prime;
	logic cand_comp;
	logic div_next;
	logic trial_init;
	logic publish;

	assign range_sum   = SUM_W'(range_start) + SUM_W'(chunk_q);
	assign limit_ext   = SUM_W'(limit_q);
	assign range_end   = (range_sum > limit_ext) ? limit_ext : range_sum;
	assign cand_live   = cand_q < {1'b0, end_q};
	assign sq_in_range = sq_q <= SQ_W'(cand_q);
	assign out_free    = !out_valid_q || out_ready;

	pctd_rem_unit #(
		.VALUE_BITS(VALUE_BITS)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (cand_q[VALUE_BITS-1:0]),
		.divisor  (div_q),
		.status   (div_status)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_CAND;
			ST_CAND:   state_d = cand_live ? ST_TRIAL : ST_FINISH;
			ST_TRIAL:  state_d = sq_in_range ? ST_DIV : ST_CAND;
			ST_DIV: begin
				if (div_status.done) state_d = div_status.rem_zero ? ST_CAND : ST_TRIAL;
			end
			ST_FINISH: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		div_start  = 1'b0;
		cand_prime = 1'b0;
		cand_comp  = 1'b0;
		div_next   = 1'b0;
		trial_init = 1'b0;
		publish    = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_CAND:   trial_init = cand_live;
			ST_TRIAL: begin
				div_start  = sq_in_range;
				cand_prime = !sq_in_range;
			end
			ST_DIV: begin
				cand_comp = div_status.done && div_status.rem_zero;
				div_next  = div_status.done && !div_status.rem_zero;
			end
			ST_FINISH: publish = out_free;
			default: ;
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			limit_q     <= LIMIT_RESET[VALUE_BITS-1:0];
			chunk_q     <= CHUNK_RESET;
		end else begin
			state_q <= state_d;
			if (publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_UPPER_LIMIT: limit_q <= cfg_data[VALUE_BITS-1:0];
					REG_CHUNK_SIZE:  chunk_q <= cfg_data[CHUNK_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cand_q  <= {1'b0, range_start};
			end_q   <= range_end[VALUE_BITS-1:0];
			count_q <= '0;
		end
		if (trial_init) begin
			div_q <= VALUE_BITS'(FIRST_DIVISOR);
			sq_q  <= SQ_W'(FIRST_DIVISOR * FIRST_DIVISOR);
		end
		if (cand_prime) begin
			count_q <= count_q + COUNT_W'(1);
		end
		if (cand_prime || cand_comp) begin
			cand_q <= cand_q + CAND_W'(2);
		end
		if (div_next) begin
			// (d+2)^2 = d^2 + 4d + 4
			div_q <= div_q + VALUE_BITS'(2);
			sq_q  <= sq_q + {div_q, 2'b00} + SQ_W'(4);
		end
		if (publish) begin
			out_count_q <= count_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign prime_count = out_count_q;

endmodule

`default_nettype wire

[hw/rtl/pctd_checker.sv]
// Port-level checker for the prime counter core, attached by bind below.
// Depends on pctd_pkg and on the core's port list.
`default_nettype none

module pctd_checker (
	input wire logic                                     clk,
	input wire logic                                     arst_n,
	input wire logic                                     in_valid,
	input wire logic                                     in_ready,
	input wire logic                                     out_valid,
	input wire logic                                     out_ready,
	input wire logic [pctd_pkg::COUNT_W-1:0]             prime_count
);
	import pctd_pkg::*;

	// a stalled count word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(prime_count))
		else $error("count word changed while stalled");

	// one range at a time: busy right after taking a word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second range word taken while busy");

	// a new count appears only at the end of a range, never straight from idle
	a_out_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("count word without a range in progress");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> prime_count <= COUNT_MAX)
		else $error("count word above the largest possible range");

endmodule

bind prime_count_trial_division_core pctd_checker u_pctd_checker (.*);

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking bench for prime_count_trial_division_core: range words in, prime counts out.
// Holds its own trial-division count predictor and drives the block with directed and random
// ranges across several limit and chunk settings. Depends on pctd_pkg and the core RTL.

module tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          VALUE_W     = 31;
	localparam int          CFG_W       = (VALUE_W > pctd_pkg::CHUNK_W) ? VALUE_W : pctd_pkg::CHUNK_W;
	localparam int          COUNT_W     = pctd_pkg::COUNT_W;
	localparam int          CHUNK_W     = pctd_pkg::CHUNK_W;
	localparam logic [30:0] VAL_MAX     = 31'h7FFF_FFFF;
	localparam logic [20:0] CHUNK_MAX   = 21'h10_0000;
	localparam int          PHASES      = 6;
	localparam int          PHASE_WORDS = 16;
	localparam int          PARK_CYCLES = 3000;
	localparam int          TAIL_CYCLES = 100;
	localparam int          MAX_CYCLES  = 10_000_000;

	// Expected prime counts, one per accepted range word, in order.
	class prime_count_board;
		logic [VALUE_W-1:0] limit;
		logic [CHUNK_W-1:0] chunk;
		logic [COUNT_W-1:0] count_q[$];
		logic [VALUE_W-1:0] start_q[$];
		int unsigned        errors;

		function new();
			limit  = pctd_pkg::LIMIT_RESET[VALUE_W-1:0];
			chunk  = pctd_pkg::CHUNK_RESET;
			errors = 0;
		endfunction

		function void load_reg(logic idx, logic [CFG_W-1:0] data);
			if (idx == pctd_pkg::REG_UPPER_LIMIT) begin
				limit = data[VALUE_W-1:0];
			end else begin
				chunk = data[CHUNK_W-1:0];
			end
		endfunction

		function bit no_odd_factor(longint unsigned v);
			longint unsigned d;
			for (d = pctd_pkg::FIRST_DIVISOR; d * d <= v; d += 2) begin
				if (v % d == 0) return 1'b0;
			end
			return 1'b1;
		endfunction

		function logic [COUNT_W-1:0] count_trial_primes(logic [VALUE_W-1:0] start);
			longint unsigned    stop;
			longint unsigned    cand;
			logic [COUNT_W-1:0] n;
			stop = start;
			stop += chunk;
			if (stop > limit) stop = limit;
			n = '0;
			for (cand = start; cand < stop; cand += 2) begin
				if (no_odd_factor(cand)) n = n + 1'b1;
			end
			return n;
		endfunction

		function void note_range(logic [VALUE_W-1:0] start);
			count_q.push_back(count_trial_primes(start));
			start_q.push_back(start);
		endfunction

		function void check_count(logic [COUNT_W-1:0] got);
			logic [COUNT_W-1:0] want;
			logic [VALUE_W-1:0] start;
			if (count_q.size() == 0) begin
				$display("%0t: prime_count expected none, got %0d", $time, got);
				errors++;
				return;
			end
			want  = count_q.pop_front();
			start = start_q.pop_front();
			if (got !== want) begin
				$display("%0t: prime_count for range_start %0d expected %0d, got %0d",
					$time, start, want, got);
				errors++;
			end
		endfunction

		function int pending();
			return count_q.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [VALUE_W-1:0] range_start;
	logic               out_valid;
	logic               out_ready;
	logic [COUNT_W-1:0] prime_count;
	logic               cfg_we;
	logic               cfg_index;
	logic [CFG_W-1:0]   cfg_data;

	prime_count_board board;
	bit               no_idle;
	bit               park_req;
	bit               sink_parked;
	int unsigned      cycle_cnt;

	prime_count_trial_division_core #(
		.VALUE_BITS(VALUE_W)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.range_start(range_start),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.prime_count(prime_count),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		cycle_cnt = 0;
		while (cycle_cnt < MAX_CYCLES) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("prime_count_trial_division_core regression: fail");
		$finish;
	end

	// Offer one range word after a random gap; return at the falling edge after acceptance.
	task automatic send_range(input logic [VALUE_W-1:0] start);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		range_start <= start;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_range(start);
		@(negedge clk);
	endtask

	// Drop valid and wait until every count has come back and the sequencer is idle.
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic load_regs(input logic [VALUE_W-1:0] lim, input logic [CHUNK_W-1:0] chk);
		cfg_we    <= 1'b1;
		cfg_index <= pctd_pkg::REG_UPPER_LIMIT;
		cfg_data  <= CFG_W'(lim);
		@(negedge clk);
		cfg_index <= pctd_pkg::REG_CHUNK_SIZE;
		cfg_data  <= CFG_W'(chk);
		@(negedge clk);
		cfg_we <= 1'b0;
		board.load_reg(pctd_pkg::REG_UPPER_LIMIT, CFG_W'(lim));
		board.load_reg(pctd_pkg::REG_CHUNK_SIZE, CFG_W'(chk));
		@(negedge clk);
	endtask

	initial begin : count_sink
		int unsigned wait_left;
		out_ready = 1'b0;
		wait_left = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				board.check_count(prime_count);
				wait_left = no_idle ? 0 : $urandom_range(0, 13);
			end
			@(negedge clk);
			out_ready <= (wait_left == 0) && !sink_parked;
			if (wait_left != 0) wait_left--;
		end
	end

	// Park the sink for a long stretch so the output register fills and input stalls.
	initial begin : sink_park
		sink_parked = 1'b0;
		wait (park_req);
		@(posedge clk);
		sink_parked = 1'b1;
		repeat (PARK_CYCLES) @(posedge clk);
		sink_parked = 1'b0;
	end

	initial begin : stim
		int                 ph;
		int                 k;
		int unsigned        kind;
		int unsigned        r;
		logic [VALUE_W-1:0] lim;
		logic [VALUE_W-1:0] s;
		logic [CHUNK_W-1:0] chk;
		board       = new();
		no_idle     = 1'b0;
		park_req    = 1'b0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		range_start = '0;
		cfg_we      = 1'b0;
		cfg_index   = pctd_pkg::REG_UPPER_LIMIT;
		cfg_data    = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: starts at and past the limit, then the last few below it
		send_range(31'd1000000);
		send_range(VAL_MAX);
		send_range(31'd999999);
		send_range(31'd999998);
		drain();

		// at most one candidate per word: small values, even values, top of the range
		load_regs(VAL_MAX, 21'd1);
		send_range(31'd0);
		send_range(31'd1);
		send_range(31'd2);
		send_range(31'd3);
		send_range(31'd4);
		send_range(31'd5);
		send_range(31'd7);
		send_range(31'd9);
		send_range(31'd2147483646);
		send_range(31'd2147483645);
		send_range(VAL_MAX);
		drain();

		load_regs(VAL_MAX, 21'd0);
		send_range(31'd1);
		drain();

		load_regs(31'd0, CHUNK_MAX);
		send_range(31'd0);
		drain();

		// widest chunk, clipped by a small limit
		load_regs(31'd200, CHUNK_MAX);
		send_range(31'd1);
		send_range(31'd0);
		drain();

		load_regs(VAL_MAX, CHUNK_MAX);
		send_range(31'd2147483646);
		drain();

		for (ph = 0; ph < PHASES; ph++) begin
			kind    = ph % 3;
			no_idle = (ph == 4);
			case (kind)
				0: begin
					lim = VALUE_W'($urandom_range(0, 4096));
					chk = ($urandom_range(0, 7) == 0) ? '0 : CHUNK_W'($urandom_range(1, 24));
				end
				1: begin
					lim = VALUE_W'($urandom_range(0, 300));
					chk = $urandom_range(0, 1) ? CHUNK_MAX
						: CHUNK_W'($urandom_range(1, 32'h10_0000));
				end
				default: begin
					lim = $urandom_range(0, 1) ? VAL_MAX
						: VALUE_W'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF));
					chk = CHUNK_W'($urandom_range(1, 2));
				end
			endcase
			load_regs(lim, chk);
			if (ph == 0) park_req = 1'b1;
			for (k = 0; k < PHASE_WORDS; k++) begin
				r = $urandom_range(0, 9);
				case (kind)
					0: begin
						if (r < 2) begin
							s = VALUE_W'($urandom);
						end else begin
							s = VALUE_W'($urandom_range(0, lim + 32));
							if (r < 8) s[0] = 1'b1;
						end
					end
					1: begin
						if (r == 0) begin
							s = VALUE_W'($urandom);
						end else begin
							s = VALUE_W'($urandom_range(0, lim + 16));
							if (r < 7) s[0] = 1'b1;
						end
					end
					default: begin
						// multiples of three stay cheap however large they are
						if (r < 7) begin
							s = VALUE_W'(3 * $urandom_range(0, 715827882));
						end else begin
							s = VALUE_W'($urandom_range(0, 4095));
						end
					end
				endcase
				send_range(s);
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("prime_count_trial_division_core regression: pass");
		end else begin
			$display("prime_count_trial_division_core regression: fail");
		end
		$finish;
	end

endmodule
